### hw/rtl/esfr_pkg.sv
// ----------------------------------------------------------------------------
// esfr_pkg
// Shared types and constants of the escape-framed byte receiver: field
// widths, register indexes, reset values and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package esfr_pkg;

  // Payload field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned LEN_W   = 6;

  // Output stream word: frame_byte, byte_index, frame_length, padded to bytes
  localparam int unsigned OUT_FIELDS_W = BYTE_W + INDEX_W + LEN_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;
  localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the byte on the input stream
    logic rd;      // issue a buffer read for the current readout index
    logic load;    // load the output register from the read data
    logic next;    // output transaction done, advance the readout index
  } esfr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic frame_done;  // the offered byte completes a frame
    logic last;        // readout index is the final byte of the frame
  } esfr_stat_t;

endpackage

### hw/rtl/esc_stx_etx_frame_receiver.sv
// ----------------------------------------------------------------------------
// esc_stx_etx_frame_receiver
// Receives bytes framed as ESC START ... ESC END, buffers the frame and
// streams it out byte by byte, with index, length and a last marker.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  rx_byte
//   m_axis    out        m_axis_tvalid/m_axis_tready  frame_byte, byte_index,
//                                                     frame_length, tlast
//   cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// An input byte is taken whenever no frame is being read out.
// A completing byte starts the readout: each frame byte goes through buffer
// read, output load and send, and the send holds while m_axis_tready is low;
// no input is taken until the last frame byte leaves.
// Reset (rst, synchronous) clears the byte count and restores the marker
// registers; buffer contents are not cleared. cfg writes are always taken.
// ----------------------------------------------------------------------------
module esc_stx_etx_frame_receiver
  import esfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] frame_byte,
                                                // [13:8] byte_index,
                                                // [19:14] frame_length, zero fill
  output logic                  m_axis_tlast,   // last_of_frame
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data
);

  esfr_cmd_t          cmd;
  esfr_stat_t         stat;
  logic [BYTE_W-1:0]  frame_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [LEN_W-1:0]   frame_length;

  assign cfg_ready = 1'b1;

  // Sequence acceptance and readout
  esfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Checks, buffer and output register
  esfr_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (s_axis_tdata),
    .frame_byte    (frame_byte),
    .byte_index    (byte_index),
    .frame_length  (frame_length),
    .last_of_frame (m_axis_tlast)
  );

  // Pack the output word
  assign m_axis_tdata = OUT_DATA_W'({frame_length, byte_index, frame_byte});

endmodule

### hw/rtl/esfr_ram.sv
// ----------------------------------------------------------------------------
// esfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module esfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/esfr_ctrl.sv
// ----------------------------------------------------------------------------
// esfr_ctrl
// Controller: accepts bytes while idle and sequences the readout of a
// completed frame (read, load, send) one byte at a time.
// ----------------------------------------------------------------------------
module esfr_ctrl
  import esfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  esfr_stat_t stat,
  output esfr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && stat.frame_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SEND;
      ST_SEND: begin
        if (out_ready) begin
          state_next = stat.last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshakes and datapath commands
  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_SEND);
  assign cmd.accept = (state == ST_IDLE) && in_valid;
  assign cmd.rd     = (state == ST_READ);
  assign cmd.load   = (state == ST_LOAD);
  assign cmd.next   = (state == ST_SEND) && out_ready;

endmodule

### hw/rtl/esfr_datapath.sv
// ----------------------------------------------------------------------------
// esfr_datapath
// Datapath: marker registers, byte count, header copies, frame buffer,
// header and marker checks, and the output register for frame readout.
// ----------------------------------------------------------------------------
module esfr_datapath
  import esfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  esfr_cmd_t             cmd,
  output esfr_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data,
  input  logic [BYTE_W-1:0]     rx_byte,
  output logic [BYTE_W-1:0]     frame_byte,
  output logic [INDEX_W-1:0]    byte_index,
  output logic [LEN_W-1:0]      frame_length,
  output logic                  last_of_frame
);

  localparam int unsigned CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);

  // Marker registers
  logic [BYTE_W-1:0] escape_byte;
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;

  // Receive state: count, header copies, last stored byte
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] hdr0;
  logic [BYTE_W-1:0] hdr1;
  logic [BYTE_W-1:0] prev_byte;

  // Readout state
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  len;
  logic [BYTE_W-1:0] ram_rdata;

  // Per-byte evaluation
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  len_next;
  logic [BYTE_W-1:0] s0;
  logic [BYTE_W-1:0] s1;
  logic              bad;
  logic              restart;
  logic              end_seen;
  logic              done;

  // Write marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RST;
      start_byte  <= START_RST;
      end_byte    <= END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE: escape_byte <= cfg_data;
        REG_START:  start_byte  <= cfg_data;
        REG_END:    end_byte    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Check the offered byte against header, depth and marker rules
  always_comb begin
    n        = byte_count + CNT_W'(1);
    s0       = (byte_count == CNT_W'(0)) ? rx_byte : hdr0;
    s1       = (byte_count == CNT_W'(1)) ? rx_byte : hdr1;
    bad      = ((n == CNT_W'(1)) && (rx_byte != escape_byte)) ||
               ((n == CNT_W'(2)) && (rx_byte != start_byte)) ||
               ((n > CNT_W'(1)) && (s0 != escape_byte) && (s1 != start_byte)) ||
               (n >= CNT_W'(BUF_DEPTH));
    restart  = !bad && (n > CNT_W'(2)) && (prev_byte == escape_byte) &&
               (rx_byte == start_byte);
    // after a restart the header is escape/start, so the end test is start vs end
    end_seen = restart ? (start_byte == end_byte)
                       : ((n > CNT_W'(1)) && (prev_byte == escape_byte) &&
                          (rx_byte == end_byte));
    len_next = restart ? CNT_W'(2) : n;
    done     = !bad && end_seen;
  end

  assign stat.frame_done = done;
  assign stat.last       = (rd_idx + CNT_W'(1) == len);

  // Update count and header copies on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (cmd.accept) begin
      if (bad || done) begin
        byte_count <= '0;
      end else begin
        byte_count <= len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_byte <= restart ? start_byte : rx_byte;
      hdr0      <= restart ? escape_byte : s0;
      hdr1      <= restart ? start_byte : s1;
    end
  end

  // Hold frame length and step the readout index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      len    <= '0;
    end else if (cmd.accept && done) begin
      rd_idx <= '0;
      len    <= len_next;
    end else if (cmd.next) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
  end

  // Frame buffer: one write per accepted byte, one read per readout byte
  esfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (byte_count[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Load the output register; header bytes come from their copies
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (rd_idx == CNT_W'(0)) begin
        frame_byte <= hdr0;
      end else if (rd_idx == CNT_W'(1)) begin
        frame_byte <= hdr1;
      end else begin
        frame_byte <= ram_rdata;
      end
      byte_index    <= INDEX_W'(rd_idx);
      frame_length  <= LEN_W'(len);
      last_of_frame <= (rd_idx + CNT_W'(1) == len);
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the escape-framed byte receiver. Byte sequences
// (well-formed frames, restarts, broken headers, noise, overflow) are streamed
// in under several marker settings, in most phases with both stream sides idling at random.
// A frame checker class predicts every emitted frame byte and compares each
// output transaction against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import esfr_pkg::*;

  localparam int unsigned DEPTH = 64;
  // Index past the last register: the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 8;

  // One emitted frame byte with its position, frame length and last marker
  typedef struct packed {
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [LEN_W-1:0]   frame_length;
    logic               last_of_frame;
  } frame_beat_t;

  // Predicts the frame bytes and checks the output stream against them
  class frame_checker;
    logic [BYTE_W-1:0] frame_buf[DEPTH];
    int unsigned       fill;
    bit                receiving;
    logic [BYTE_W-1:0] esc_marker;
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
    frame_beat_t       pending_beats[$];
    int unsigned       errors;
    int unsigned       frames_done;
    int unsigned       beats_checked;
    int unsigned       discards;
    int unsigned       restarts;

    function new();
      fill         = 0;
      receiving    = 1'b0;
      esc_marker   = ESCAPE_RST;
      start_marker = START_RST;
      end_marker   = END_RST;
      errors = 0; frames_done = 0; beats_checked = 0; discards = 0; restarts = 0;
    endfunction

    function void write_marker(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_ESCAPE: esc_marker = val;
        REG_START:  start_marker = val;
        REG_END:    end_marker = val;
        default: ;
      endcase
    endfunction

    // Advance the receiver by one accepted byte; queue a frame when it completes
    function void take_rx_byte(logic [BYTE_W-1:0] b);
      int unsigned n;
      frame_beat_t beat;
      if (fill < DEPTH) frame_buf[fill] = b;
      n = fill + 1;
      // Drop the buffer on a bad header or when it fills up
      if ((n == 1 && frame_buf[0] != esc_marker) ||
          (n == 2 && frame_buf[1] != start_marker) ||
          (n > 1 && frame_buf[0] != esc_marker && frame_buf[1] != start_marker) ||
          (n >= DEPTH)) begin
        fill = 0;
        receiving = 1'b0;
        discards++;
        return;
      end
      receiving = 1'b1;
      // Escape/start later in the frame restarts it at a fresh header
      if (n > 2 && frame_buf[n-2] == esc_marker && frame_buf[n-1] == start_marker) begin
        frame_buf[0] = esc_marker;
        frame_buf[1] = start_marker;
        n = 2;
        restarts++;
      end
      fill = n;
      // Escape/end closes the frame: emit it whole, header and trailer included
      if (n > 1 && frame_buf[n-2] == esc_marker && frame_buf[n-1] == end_marker) begin
        for (int k = 0; k < n; k++) begin
          beat.frame_byte    = frame_buf[k];
          beat.byte_index    = k[INDEX_W-1:0];
          beat.frame_length  = n[LEN_W-1:0];
          beat.last_of_frame = (k + 1 == n);
          pending_beats.push_back(beat);
        end
        fill = 0;
        receiving = 1'b0;
        frames_done++;
      end
    endfunction

    function void report(string field, int unsigned exp_val, int unsigned act_val);
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, exp_val,
               act_val);
      errors++;
    endfunction

    // Compare one output transaction with the oldest predicted frame byte
    function void check_beat(logic [OUT_DATA_W-1:0] data, logic last);
      frame_beat_t exp_beat;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected frame byte: expected none, actual tdata %0h tlast %0b",
                 $time, data, last);
        errors++;
        return;
      end
      exp_beat = pending_beats.pop_front();
      beats_checked++;
      if (data[7:0] != exp_beat.frame_byte)
        report("frame_byte", 32'(exp_beat.frame_byte), 32'(data[7:0]));
      if (data[13:8] != exp_beat.byte_index)
        report("byte_index", 32'(exp_beat.byte_index), 32'(data[13:8]));
      if (data[19:14] != exp_beat.frame_length)
        report("frame_length", 32'(exp_beat.frame_length), 32'(data[19:14]));
      if (last !== exp_beat.last_of_frame)
        report("last_of_frame", 32'(exp_beat.last_of_frame), 32'(last));
      if (data[OUT_DATA_W-1:OUT_FIELDS_W] != '0)
        report("tdata fill", 0, 32'(data[OUT_DATA_W-1:OUT_FIELDS_W]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;    // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;    // [7:0] frame_byte, [13:8] byte_index,
                                          // [19:14] frame_length, zero fill
  logic                  m_axis_tlast;    // last_of_frame
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [BYTE_W-1:0]     cfg_data;

  frame_checker chk;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_request;
  int unsigned  hold_left;
  int unsigned  items_sent;
  int unsigned  seq_count;

  // Marker settings of the random phases: defaults, extremes, escape equal to
  // start, start equal to end
  logic [BYTE_W-1:0] phase_esc[PHASES]   = '{8'h1B, 8'h00, 8'h7E, 8'hA5, 8'hFF};
  logic [BYTE_W-1:0] phase_start[PHASES] = '{8'h02, 8'hFF, 8'h7E, 8'h5A, 8'h01};
  logic [BYTE_W-1:0] phase_end[PHASES]   = '{8'h03, 8'h80, 8'h7D, 8'h5A, 8'h00};

  esc_stx_etx_frame_receiver #(.BUF_DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d frame bytes still pending", $time,
             chk.pending_beats.size());
    $display("FAIL");
    $finish;
  end

  // Receiver side: random stalls, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) chk.check_beat(m_axis_tdata, m_axis_tlast);
  end

  // Offer one byte after a random idle gap; hold until the transaction
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chk.take_rx_byte(b);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted frame byte has left
  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (chk.pending_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Hold cfg_valid across one register transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.write_marker(idx, val);
  endtask

  task automatic set_markers(input logic [7:0] e, input logic [7:0] s, input logic [7:0] t);
    write_reg(REG_ESCAPE, e);
    write_reg(REG_START, s);
    write_reg(REG_END, t);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] not_escape(input logic [7:0] b);
    return (b == chk.esc_marker) ? (b ^ 8'h01) : b;
  endfunction

  // One random byte sequence built around the current markers
  task automatic send_sequence();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  e;
    logic [7:0]  s;
    logic [7:0]  t;
    e = chk.esc_marker;
    s = chk.start_marker;
    t = chk.end_marker;
    kind = $urandom_range(0, 99);
    seq_count++;
    if (seq_count == 3) begin
      // Header and clean payload until the buffer fills and is dropped
      send_byte(e);
      send_byte(s);
      repeat (DEPTH - 2) send_byte(not_escape(8'($urandom_range(0, 255))));
    end else if (seq_count == 5) begin
      // Longest frame that fits
      send_byte(e);
      send_byte(s);
      repeat (DEPTH - 5) send_byte(not_escape(8'($urandom_range(0, 255))));
      send_byte(e);
      send_byte(t);
    end else if (kind < 55) begin
      // Well-formed frame, mostly short
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      send_byte(e);
      send_byte(s);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      send_byte(e);
      send_byte(t);
    end else if (kind < 67) begin
      // Restart inside a frame, then close it
      send_byte(e);
      send_byte(s);
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
      send_byte(e);
      send_byte(s);
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
      send_byte(e);
      send_byte(t);
    end else if (kind < 77) begin
      // Escape followed by a random second byte
      send_byte(e);
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 88) begin
      // Line noise
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // Frame cut short; the next sequence lands in the middle of it
      send_byte(e);
      send_byte(s);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned phase_first;
    chk            = new();
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ESCAPE;
    cfg_data       = 8'h00;
    send_idle_pct  = 38;
    recv_stall_pct = 56;
    hold_request   = 0;
    hold_left      = 0;
    items_sent     = 0;
    seq_count      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: frame with extreme payload bytes under the reset markers
    send_byte(8'h1B); send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h1B); send_byte(8'h03);
    // Bad first byte, then bad second byte
    send_byte(8'h00);
    send_byte(8'h1B); send_byte(8'h05);
    // Long receiver hold-off while a restarted frame completes and more
    // bytes queue up behind its readout
    hold_request = 200;
    send_byte(8'h1B); send_byte(8'h02); send_byte(8'h11);
    send_byte(8'h1B); send_byte(8'h02); send_byte(8'h1B); send_byte(8'h03);
    send_byte(8'h1B); send_byte(8'h02);
    // Marker change mid-frame drops the frame under way; start equal to end
    // then lets a two-byte frame complete
    drain(8);
    set_markers(8'hFF, 8'h00, 8'h00);
    send_byte(8'h44);
    send_byte(8'hFF); send_byte(8'h00);

    // Random phases, each under its own marker setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct  = 56;
        recv_stall_pct = 38;
      end else if (p == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      drain(8);
      if (p == 2) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
      set_markers(phase_esc[p], phase_start[p], phase_end[p]);
      phase_first = items_sent;
      while (items_sent - phase_first < PHASE_ITEMS) send_sequence();
    end

    drain(200);
    $display("Sent %0d bytes under %0d marker settings: %0d frames, %0d frame bytes checked,",
             items_sent, PHASES + 2, chk.frames_done, chk.beats_checked);
    $display("%0d buffers dropped, %0d restarts inside a frame.", chk.discards, chk.restarts);
    if (chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
